/* rtl/core/kpdf_pkg.sv */
// Shared types and constants for the key press duplicate filter.
// Used by the top level and by its port checker; no dependencies.
package kpdf_pkg;

   // History ring depth default and field widths
   localparam int HISTORY_DEPTH = 256;
   localparam int CODE_W        = 16;
   localparam int FLAGS_W       = 16;
   localparam int TIME_W        = 63;
   localparam int THR_W         = 16;

   // Window in ticks: 65535 ms * 10000 ticks still fits in 30 bits
   localparam int WIN_W = 30;

   localparam logic [13:0]      TICKS_PER_MS    = 14'd10000;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd50;

   // Beat layout on the stream ports
   localparam int REQ_DATA_W  = 80;
   localparam int REQ_USER_W  = 16;
   localparam int RSP_DATA_W  = 8;

   // Sequencer states
   typedef enum logic [1:0] {
      KPDF_IDLE,
      KPDF_SCAN,
      KPDF_RESULT
   } state_type;

endpackage

/* rtl/core/key_press_duplicate_filter_top.sv */
// Key press duplicate filter: history ring in one synchronous memory,
// scanned one entry a cycle. Depends on kpdf_pkg.
//
// A release goes straight to the result state; a press scans the valid ring
// entries (fill, at most HISTORY_DEPTH) and stops early on a match. One
// event at a time: the single memory read port is busy with the scan, and
// no new event is taken until the last result is loaded.
// Reset (synchronous) empties the ring through its fill count at once.
module key_press_duplicate_filter_top #(
   parameter int HISTORY_DEPTH = kpdf_pkg::HISTORY_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // Event beats
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [15:0] key_code, [78:16] time_now, [79] zero
   input  logic [kpdf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [15:0] key_flags
   input  logic [kpdf_pkg::REQ_USER_W-1:0]  req_tuser,
   // Result beats
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] is_duplicate, [7:1] zero
   output logic [kpdf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Threshold register
   input  logic                             csr_wr_en,
   input  logic [kpdf_pkg::THR_W-1:0]       csr_wr_data
);

   localparam int AW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW      = $clog2(HISTORY_DEPTH + 1);
   localparam int ENTRY_W = kpdf_pkg::CODE_W + kpdf_pkg::TIME_W;
   localparam logic [kpdf_pkg::WIN_W-1:0] WINDOW_RESET =
      kpdf_pkg::WIN_W'(kpdf_pkg::THRESHOLD_RESET) * kpdf_pkg::WIN_W'(kpdf_pkg::TICKS_PER_MS);
   localparam logic signed [63:0] NEG_ONE_MS = -64'sd10000;

   kpdf_pkg::state_type state_ff, state_in;

   logic [kpdf_pkg::CODE_W-1:0] code_ff;
   logic [kpdf_pkg::TIME_W-1:0] now_ff;
   logic                        dup_ff, dup_in;
   logic [CW-1:0]               scan_ff, scan_in;
   logic                        pend_ff, pend_in;
   logic [AW-1:0]               slot_ff, slot_in;
   logic [CW-1:0]               fill_ff, fill_in;
   logic [kpdf_pkg::WIN_W-1:0]  window_ff, window_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_dup_ff;

   logic [ENTRY_W-1:0] mem [HISTORY_DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   logic        req_accept, is_release;
   logic        issue, match, store, load_rsp;
   logic [63:0] diff;
   logic        in_window;
   logic [kpdf_pkg::CODE_W-1:0] ent_code;
   logic [kpdf_pkg::TIME_W-1:0] ent_time;

   assign req_accept = req_tvalid && req_tready;
   assign is_release = (req_tuser != '0);

   // Entry compare on the registered read data
   assign ent_code = rdata_ff[kpdf_pkg::CODE_W-1:0];
   assign ent_time = rdata_ff[ENTRY_W-1:kpdf_pkg::CODE_W];
   assign diff     = {1'b0, now_ff} - {1'b0, ent_time};

   always_comb begin
      if (diff[63]) begin
         // time went backwards: quotient is zero or negative
         in_window = (window_ff != '0) || ($signed(diff) <= NEG_ONE_MS);
      end else begin
         in_window = diff < {{(64 - kpdf_pkg::WIN_W){1'b0}}, window_ff};
      end
   end

   // Control outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      match      = 1'b0;
      store      = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         kpdf_pkg::KPDF_IDLE: begin
            req_tready = 1'b1;
         end
         kpdf_pkg::KPDF_SCAN: begin
            issue = (scan_ff < fill_ff);
            match = pend_ff && (ent_code == code_ff) && in_window;
            store = !issue && !pend_ff;
         end
         kpdf_pkg::KPDF_RESULT: begin
            load_rsp = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kpdf_pkg::KPDF_IDLE: begin
            if (req_accept) begin
               state_in = is_release ? kpdf_pkg::KPDF_RESULT : kpdf_pkg::KPDF_SCAN;
            end
         end
         kpdf_pkg::KPDF_SCAN: begin
            if (match || store) begin
               state_in = kpdf_pkg::KPDF_RESULT;
            end
         end
         kpdf_pkg::KPDF_RESULT: begin
            if (load_rsp) begin
               state_in = kpdf_pkg::KPDF_IDLE;
            end
         end
         default: begin
            state_in = kpdf_pkg::KPDF_IDLE;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      dup_in    = dup_ff;
      scan_in   = scan_ff;
      pend_in   = (state_ff == kpdf_pkg::KPDF_SCAN) && issue && !match;
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      window_in = window_ff;
      if (req_accept) begin
         dup_in  = 1'b0;
         scan_in = '0;
      end
      if (issue && !match) begin
         scan_in = scan_ff + CW'(1);
      end
      if (match) begin
         dup_in = 1'b1;
      end
      // new press goes into the ring, oldest slot first
      if (store) begin
         slot_in = (slot_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + AW'(1);
         if (fill_ff != CW'(HISTORY_DEPTH)) begin
            fill_in = fill_ff + CW'(1);
         end
      end
      if (csr_wr_en) begin
         window_in = kpdf_pkg::WIN_W'(csr_wr_data) * kpdf_pkg::WIN_W'(kpdf_pkg::TICKS_PER_MS);
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpdf_pkg::KPDF_IDLE;
         pend_ff      <= 1'b0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         window_ff    <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         code_ff <= req_tdata[kpdf_pkg::CODE_W-1:0];
         now_ff  <= req_tdata[kpdf_pkg::CODE_W +: kpdf_pkg::TIME_W];
      end
      dup_ff  <= dup_in;
      scan_ff <= scan_in;
      if (load_rsp) begin
         rsp_dup_ff <= dup_ff;
      end
   end

   // History ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store) begin
         mem[slot_ff] <= {now_ff, code_ff};
      end
      rdata_ff <= mem[scan_ff[AW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(kpdf_pkg::RSP_DATA_W - 1){1'b0}}, rsp_dup_ff};

endmodule

/* rtl/core/kpdf_checker.sv */
// Port-level checks for the key press duplicate filter, bound to the top.
// Depends on kpdf_pkg and key_press_duplicate_filter_top.
module kpdf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [kpdf_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [kpdf_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [kpdf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            csr_wr_en,
   input logic [kpdf_pkg::THR_W-1:0]      csr_wr_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one event in flight: no new beat right after one is taken
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   // padding above the duplicate flag stays zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[kpdf_pkg::RSP_DATA_W-1:1] == '0)
      else $error("result padding not zero");

   // reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind key_press_duplicate_filter_top kpdf_checker u_kpdf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .req_tdata   (req_tdata),
   .req_tuser   (req_tuser),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);
